>>> rtl/core/srs_pkg.sv
// Shared sizes, codes, types and the LFSR step for the shuffled recycle stack.
`default_nettype none

package srs_pkg;

    localparam int PILE_DEPTH = 64;
    localparam int ELEM_BITS  = 32;
    localparam int ADDR_W     = $clog2(PILE_DEPTH);
    localparam int CNT_W      = $clog2(PILE_DEPTH + 1);
    localparam int RAND_BITS  = 32;
    localparam int DIV_CNT_W  = $clog2(RAND_BITS + 1);

    localparam logic [RAND_BITS-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [RAND_BITS-1:0] LFSR_SAFE = 32'd1;

    localparam logic ACT_DISCARD = 1'b0;
    localparam logic ACT_DRAW    = 1'b1;

    typedef logic [ELEM_BITS-1:0] elem_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [RAND_BITS-1:0] rand_t;

    typedef enum logic [1:0] {
        STAT_DRAWN    = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_ACCEPTED = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_COPY_RD,
        S_COPY_WR,
        S_RAND,
        S_DIV,
        S_RD_I,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_POP_RD,
        S_POP_WAIT,
        S_RESULT
    } state_t;

    // handshake between sequencer and the remainder unit
    typedef struct packed {
        logic  start;
        rand_t dividend;
        cnt_t  divisor;
    } mod_req_t;

    typedef struct packed {
        logic done;
        cnt_t rem;
    } mod_rsp_t;

    function automatic rand_t lfsr_step(input rand_t v);
        rand_t taps;
        taps = v[0] ? LFSR_TAPS : '0;
        return (v >> 1) ^ taps;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/srs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/srs_mod_unit.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
`default_nettype none

module srs_mod_unit
    import srs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mod_req_t req,
    output mod_rsp_t      rsp
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    rand_t                shift_reg;
    cnt_t                 rem_reg;
    cnt_t                 rem_next;
    cnt_t                 div_reg;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;

    always_comb begin
        trial = {rem_reg, shift_reg[RAND_BITS-1]};
        diff  = trial - {1'b0, div_reg};
        // rem < divisor, so trial < 2*divisor and one subtract is enough
        rem_next = (trial >= {1'b0, div_reg}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            cnt_reg  <= DIV_CNT_W'(RAND_BITS);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            shift_reg <= req.dividend;
            rem_reg   <= '0;
            div_reg   <= req.divisor;
        end else if (cnt_reg != '0) begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/shuffled_recycle_stack_core.sv
// Top level: draw/discard piles with Fisher-Yates reshuffle under a sequencer.
//
//  channel  | dir | beat qualifier        | contents
//  ---------+-----+-----------------------+--------------------------------------
//  cfg      | in  | cfg_valid & cfg_ready | cfg_data = random_seed (reloads LFSR)
//  s_       | in  | s_tvalid & s_tready   | tdata = element_in, tuser = action
//  m_       | out | m_tvalid & m_tready   | tdata = element_out, tuser = status
//
//  Discard: accept, decode, result. Draw from a non-empty pile: accept, decode,
//  pop read, pop wait, result. A recycling draw copies each discard (read, write),
//  then per element: LFSR step, remainder, read i, read j, write i, write j; then the pop.
//  One item is in flight at a time; s_tready is high only between items.
//  Reset (aresetn low, synchronous) empties both piles and loads seed 1.
//  A result waiting on m_tready holds the sequencer in its result step.
`default_nettype none

module shuffled_recycle_stack_core
    import srs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] element_in
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] element_out
    output logic      [1:0]  m_tuser    // [1:0] status
);

    state_t  state_reg, state_next;
    logic    action_reg, action_next;
    elem_t   elem_reg, elem_next;
    cnt_t    draw_cnt_reg, draw_cnt_next;
    cnt_t    disc_cnt_reg, disc_cnt_next;
    cnt_t    idx_reg, idx_next;
    addr_t   j_reg, j_next;
    elem_t   tmp_reg, tmp_next;
    rand_t   lfsr_reg, lfsr_next;
    elem_t   res_data_reg, res_data_next;
    status_t res_stat_reg, res_stat_next;
    logic    m_valid_reg, m_valid_next;
    elem_t   m_data_reg, m_data_next;
    status_t m_stat_reg, m_stat_next;

    logic    draw_we, disc_we;
    addr_t   draw_waddr, draw_raddr, disc_waddr, disc_raddr;
    elem_t   draw_wdata, disc_wdata, draw_rdata, disc_rdata;

    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    cnt_t    idx_inc;
    cnt_t    j_sum;
    logic    copy_last, shuf_last, out_free;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign j_sum     = idx_reg + mod_rsp.rem;
    assign copy_last = (idx_inc == disc_cnt_reg);
    assign shuf_last = (idx_inc == draw_cnt_reg);
    assign out_free  = !m_valid_reg || m_tready;

    srs_ram #(.WIDTH(ELEM_BITS), .DEPTH(PILE_DEPTH)) u_draw_ram (
        .aclk    (aclk),
        .wr_en   (draw_we),
        .wr_addr (draw_waddr),
        .wr_data (draw_wdata),
        .rd_addr (draw_raddr),
        .rd_data (draw_rdata)
    );

    srs_ram #(.WIDTH(ELEM_BITS), .DEPTH(PILE_DEPTH)) u_disc_ram (
        .aclk    (aclk),
        .wr_en   (disc_we),
        .wr_addr (disc_waddr),
        .wr_data (disc_wdata),
        .rd_addr (disc_raddr),
        .rd_data (disc_rdata)
    );

    srs_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_DECODE;
            S_DECODE: begin
                if (action_reg == ACT_DISCARD) state_next = S_RESULT;
                else if (draw_cnt_reg != '0)   state_next = S_POP_RD;
                else if (disc_cnt_reg == '0)   state_next = S_RESULT;
                else                           state_next = S_COPY_RD;
            end
            S_COPY_RD:  state_next = S_COPY_WR;
            S_COPY_WR:  state_next = copy_last ? S_RAND : S_COPY_RD;
            S_RAND:     state_next = S_DIV;
            S_DIV:      if (mod_rsp.done) state_next = S_RD_I;
            S_RD_I:     state_next = S_RD_J;
            S_RD_J:     state_next = S_WR_I;
            S_WR_I:     state_next = S_WR_J;
            S_WR_J:     state_next = shuf_last ? S_POP_RD : S_RAND;
            S_POP_RD:   state_next = S_POP_WAIT;
            S_POP_WAIT: state_next = S_RESULT;
            S_RESULT:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        action_next   = action_reg;
        elem_next     = elem_reg;
        draw_cnt_next = draw_cnt_reg;
        disc_cnt_next = disc_cnt_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        tmp_next      = tmp_reg;
        lfsr_next     = lfsr_reg;
        res_data_next = res_data_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_stat_next   = m_stat_reg;

        s_tready   = 1'b0;
        draw_we    = 1'b0;
        draw_waddr = idx_reg[ADDR_W-1:0];
        draw_wdata = draw_rdata;
        draw_raddr = idx_reg[ADDR_W-1:0];
        disc_we    = 1'b0;
        disc_waddr = disc_cnt_reg[ADDR_W-1:0];
        disc_wdata = elem_reg;
        disc_raddr = idx_reg[ADDR_W-1:0];

        mod_req.start    = 1'b0;
        mod_req.dividend = lfsr_step(lfsr_reg);
        mod_req.divisor  = draw_cnt_reg - idx_reg;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                action_next = s_tuser[0];
                elem_next   = s_tdata[ELEM_BITS-1:0];
            end
            S_DECODE: begin
                res_data_next = '0;
                idx_next      = '0;
                if (action_reg == ACT_DISCARD) begin
                    if (disc_cnt_reg != CNT_W'(PILE_DEPTH)) begin
                        disc_we       = 1'b1;
                        disc_cnt_next = disc_cnt_reg + CNT_W'(1);
                        res_stat_next = STAT_ACCEPTED;
                    end else begin
                        res_stat_next = STAT_OVERFLOW;
                    end
                end else begin
                    res_stat_next = STAT_EMPTY;
                end
            end
            S_COPY_WR: begin
                draw_we    = 1'b1;
                draw_wdata = disc_rdata;
                if (copy_last) begin
                    draw_cnt_next = disc_cnt_reg;
                    disc_cnt_next = '0;
                    idx_next      = '0;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_RAND: begin
                mod_req.start = 1'b1;
                lfsr_next     = lfsr_step(lfsr_reg);
            end
            S_DIV: begin
                if (mod_rsp.done) j_next = j_sum[ADDR_W-1:0];
            end
            S_RD_J: begin
                draw_raddr = j_reg;
                tmp_next   = draw_rdata;      // pile[i]
            end
            S_WR_I: begin
                draw_we = 1'b1;               // pile[i] <= pile[j]
            end
            S_WR_J: begin
                draw_we    = 1'b1;
                draw_waddr = j_reg;
                draw_wdata = tmp_reg;
                idx_next   = idx_inc;
            end
            S_POP_RD: begin
                draw_cnt_next = draw_cnt_reg - CNT_W'(1);
                draw_raddr    = draw_cnt_next[ADDR_W-1:0];
            end
            S_POP_WAIT: begin
                res_data_next = draw_rdata;
                res_stat_next = STAT_DRAWN;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_stat_next  = res_stat_reg;
                end
            end
            default: begin
            end
        endcase

        // the user must send seed writes only between items; the block does not enforce it
        if (cfg_valid) lfsr_next = (cfg_data != '0) ? cfg_data : LFSR_SAFE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            draw_cnt_reg <= '0;
            disc_cnt_reg <= '0;
            lfsr_reg     <= LFSR_SAFE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            draw_cnt_reg <= draw_cnt_next;
            disc_cnt_reg <= disc_cnt_next;
            lfsr_reg     <= lfsr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        elem_reg     <= elem_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        tmp_reg      <= tmp_next;
        res_data_reg <= res_data_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
        m_stat_reg   <= m_stat_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = 32'(m_data_reg);
    assign m_tuser   = m_stat_reg;

    a_counts_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (draw_cnt_reg <= CNT_W'(PILE_DEPTH)) && (disc_cnt_reg <= CNT_W'(PILE_DEPTH)))
        else $error("pile count beyond depth");

    a_swap_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD_I) |->
            (CNT_W'(j_reg) >= idx_reg) && (CNT_W'(j_reg) < draw_cnt_reg))
        else $error("shuffle swap index outside remaining pile");

    a_lfsr_live: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("LFSR locked at zero");

    a_discard_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE && action_reg == ACT_DISCARD &&
         disc_cnt_reg != CNT_W'(PILE_DEPTH)) |=>
            disc_cnt_reg == $past(disc_cnt_reg) + CNT_W'(1))
        else $error("accepted discard did not grow the pile");

endmodule

`default_nettype wire
